// ===== hw/rtl/noc_traffic_destination_unit_defines.svh =====
// Assertion helpers for the destination unit RTL.
`ifndef NOC_TRAFFIC_DESTINATION_UNIT_DEFINES_SVH
`define NOC_TRAFFIC_DESTINATION_UNIT_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define NTD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk, off during reset.
`define NTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ntd_pkg.sv =====
package ntd_pkg;

    typedef logic [2:0] t_pattern;
    typedef logic [1:0] t_reg_index;

    // traffic pattern codes
    localparam t_pattern PAT_TRANSPOSE  = 3'd0;
    localparam t_pattern PAT_REVERSAL   = 3'd1;
    localparam t_pattern PAT_SHUFFLE    = 3'd2;
    localparam t_pattern PAT_BUTTERFLY  = 3'd3;
    localparam t_pattern PAT_COMPLEMENT = 3'd4;
    localparam t_pattern PAT_TORNADO    = 3'd5;
    localparam t_pattern PAT_ALL_TO_ALL = 3'd6;

    // configuration register indexes
    localparam t_reg_index REG_PATTERN    = 2'd0;
    localparam t_reg_index REG_NODE_COUNT = 2'd1;
    localparam t_reg_index REG_RADIX      = 2'd2;
    localparam t_reg_index REG_DIMENSIONS = 2'd3;

    // register widths fixed by the register map
    localparam int PAT_W = 3;
    localparam int DIM_W = 3;

    // reset values
    localparam int RST_PATTERN    = 0;
    localparam int RST_NODE_COUNT = 16;
    localparam int RST_RADIX      = 4;
    localparam int RST_DIMENSIONS = 2;

endpackage

// ===== hw/rtl/ntd_src_if.sv =====
interface ntd_src_if #(
    parameter int NODE_W = 10
) ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] source_node;

    modport source (output valid, output source_node, input ready);
    modport sink   (input valid, input source_node, output ready);
endinterface

// ===== hw/rtl/ntd_dst_if.sv =====
interface ntd_dst_if #(
    parameter int NODE_W = 10
) ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] destination_node;
    logic              unchanged_error;

    modport source (output valid, output destination_node, output unchanged_error, input ready);
    modport sink   (input valid, input destination_node, input unchanged_error, output ready);
endinterface

// ===== hw/rtl/ntd_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module ntd_divider #(
    parameter int DVD_W = 12,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W-1:0] n_rem;

    // bring down the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        fits  = (trial >= {1'b0, r_dvs});
        n_rem = fits ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DVD_W-2:0], fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// ===== hw/rtl/noc_traffic_destination_unit.sv =====
// Path, transfer in to result valid: bit patterns and all-to-all load the result register
// and then the output register; tornado with count > 0 first takes one shared serial divider pass.
// Transpose: splits, reversed-order assembly, and the original-order retry if it runs;
//   one division per dimension on the shared divider, one multiply-add per coordinate.
// Throughput: one item at a time; the next is taken once the result is handed off.
// Reset (synchronous, active low) restores register defaults and clears the pointer.
`include "noc_traffic_destination_unit_defines.svh"

module noc_traffic_destination_unit #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_DIMS  = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ntd_src_if.sink                     i_src,
    ntd_dst_if.source                   o_dst,
    input  logic                        i_cfg_we,
    input  ntd_pkg::t_reg_index         i_cfg_index,
    input  logic [$clog2(MAX_NODES):0]  i_cfg_data
);
    import ntd_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);          // node number width
    localparam int CW  = NW + 1;                     // node count / radix width
    localparam int VW  = NW + 2;                     // divider dividend width
    localparam int BW  = $clog2(NW + 1);             // bit-length width
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DCW = $clog2(MAX_DIMS + 1);
    localparam int MW  = NW + CW + 1;                // multiply-add width

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TDIV = 3'd1;   // tornado modulo on the divider
    localparam logic [2:0] S_XDIV = 3'd2;   // transpose coordinate split
    localparam logic [2:0] S_ASM1 = 3'd3;   // reversed-order assembly
    localparam logic [2:0] S_ASM2 = 3'd4;   // original-order assembly
    localparam logic [2:0] S_OUT  = 3'd5;   // hand result to output register

    // configuration registers
    logic [PAT_W-1:0] r_pattern;
    logic [CW-1:0]    r_node_count;
    logic [CW-1:0]    r_radix;
    logic [DIM_W-1:0] r_dims;

    // sequencer and datapath
    logic [2:0]       r_state;
    logic [NW-1:0]    r_src;
    logic [NW-1:0]    r_ptr;
    logic [DCW-1:0]   r_dim_cnt;
    logic [DCW-1:0]   r_asm_cnt;
    logic [CW-1:0]    r_coord [MAX_DIMS];
    logic [NW-1:0]    r_acc;
    logic             r_big;
    logic [NW-1:0]    r_res_dst;
    logic             r_res_err;
    logic             r_div_start;
    logic [VW-1:0]    r_div_dvd;
    logic [CW-1:0]    r_div_dvs;
    logic             r_out_valid;
    logic [NW-1:0]    r_out_dst;
    logic             r_out_err;

    logic             in_acc;
    logic             out_load;
    logic [CW-1:0]    radix_eff;
    logic [DCW-1:0]   dims_eff;
    logic             div_done;
    logic [VW-1:0]    div_quo;
    logic [CW-1:0]    div_rem;

    assign in_acc   = i_src.valid && i_src.ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_dst.ready);

    // a radix below two counts as two; dimensions clamp at MAX_DIMS
    assign radix_eff = (r_radix < CW'(2)) ? CW'(2) : r_radix;
    assign dims_eff  = (int'(r_dims) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(r_dims);

    // ---------------------------------------------------------------
    // Bit patterns: work on the low b bits (at least 1, at most NW), b = bit length of count-1
    // ---------------------------------------------------------------
    logic [CW-1:0] nc_m1;
    logic [BW-1:0] b_len;
    logic [NW-1:0] mask;
    logic [NW-1:0] s_low;
    logic [NW-1:0] rev;
    logic [NW-1:0] rev_dst;
    logic [NW-1:0] shuf_dst;
    logic [NW-1:0] bfly_dst;
    logic          bfly_hi;
    logic [NW-1:0] bfly_flip;

    always_comb begin
        nc_m1 = r_node_count - CW'(1);
        b_len = BW'(1);
        for (int k = 1; k < NW; k++) begin
            if (nc_m1[k]) begin
                b_len = BW'(k + 1);
            end
        end
        // top bit set: cap at the node width
        if (nc_m1[NW]) begin
            b_len = BW'(NW);
        end
        if (r_node_count < CW'(3)) begin
            b_len = BW'(1);
        end
        for (int k = 0; k < NW; k++) begin
            mask[k] = (k < int'(b_len));
        end
        s_low = i_src.source_node & mask;

        for (int k = 0; k < NW; k++) begin
            rev[NW-1-k] = s_low[k];
        end
        rev_dst = rev >> (BW'(NW) - b_len);
        if (rev_dst == s_low) begin
            rev_dst = rev_dst ^ mask;
        end

        shuf_dst = ((s_low << 1) & mask) | (s_low >> (b_len - BW'(1)));
        if (shuf_dst == s_low) begin
            shuf_dst = shuf_dst ^ mask;
        end

        // butterfly: swap top and bottom bit of the field
        bfly_hi   = s_low[0] ^ ((s_low >> (b_len - BW'(1))) != NW'(0));
        bfly_flip = (NW'(1) << (b_len - BW'(1))) | NW'(1);
        bfly_dst  = bfly_hi ? (s_low ^ bfly_flip) : s_low;
        if (bfly_dst == s_low) begin
            bfly_dst = bfly_dst ^ mask;
        end
    end

    // ---------------------------------------------------------------
    // All-to-all: skip the source, wrap to zero at the node count
    // ---------------------------------------------------------------
    function automatic logic [NW-1:0] f_inc(input logic [NW-1:0] p, input logic [CW-1:0] nc);
        logic [CW-1:0] q;
        q = CW'(p) + CW'(1);
        return (q >= nc) ? '0 : q[NW-1:0];
    endfunction

    logic [NW-1:0] a2a_dst;
    assign a2a_dst = (r_ptr == i_src.source_node) ? f_inc(r_ptr, r_node_count) : r_ptr;

    // tornado numerator: source + count/2 + count - 1
    logic [VW-1:0] torn_num;
    assign torn_num = VW'(i_src.source_node) + VW'(r_node_count >> 1) + VW'(r_node_count)
                    - VW'(1);

    // ---------------------------------------------------------------
    // Transpose assembly: one multiply-add per coordinate. Keep only the
    // low node bits and a sticky flag for anything above them; a radix
    // of two or more keeps a large value large.
    // ---------------------------------------------------------------
    logic [DIW-1:0] asm_idx;
    logic [DCW-1:0] asm_rev;
    logic [CW-1:0]  coord_sel;
    logic [MW-1:0]  mac;
    logic           mac_big;
    logic [NW-1:0]  mac_low;
    logic           mac_eq;
    logic           asm_last;

    always_comb begin
        asm_rev   = dims_eff - DCW'(1) - r_asm_cnt;
        asm_idx   = (r_state == S_ASM2) ? asm_rev[DIW-1:0] : r_asm_cnt[DIW-1:0];
        coord_sel = r_coord[asm_idx];
        mac       = MW'(r_acc) * MW'(radix_eff) + MW'(coord_sel);
        mac_big   = r_big || (mac[MW-1:NW] != '0);
        mac_low   = mac[NW-1:0];
        mac_eq    = !mac_big && (mac_low == r_src);
        asm_last  = (r_asm_cnt + DCW'(1)) == dims_eff;
    end

    // ---------------------------------------------------------------
    // Shared divider: tornado modulo and transpose coordinate split
    // ---------------------------------------------------------------
    ntd_divider #(
        .DVD_W (VW),
        .DVS_W (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_start),
        .i_dividend  (r_div_dvd),
        .i_divisor   (r_div_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ptr        <= '0;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pattern    <= PAT_W'(RST_PATTERN);
            r_node_count <= CW'(RST_NODE_COUNT);
            r_radix      <= CW'(RST_RADIX);
            r_dims       <= DIM_W'(RST_DIMENSIONS);
        end else begin
            r_div_start <= 1'b0;

            // the host writes registers only while the unit is idle: a rule for the host, the block does not enforce it
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_PATTERN:    r_pattern    <= i_cfg_data[PAT_W-1:0];
                    REG_NODE_COUNT: r_node_count <= i_cfg_data;
                    REG_RADIX:      r_radix      <= i_cfg_data;
                    REG_DIMENSIONS: r_dims       <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            // output register: drop on transfer, load a finished result
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_dst   <= r_res_dst;
                r_out_err   <= r_res_err;
            end else if (o_dst.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_src     <= i_src.source_node;
                        r_res_err <= 1'b0;
                        r_state   <= S_OUT;
                        case (r_pattern)
                            PAT_TRANSPOSE: begin
                                r_dim_cnt <= '0;
                                r_div_dvd <= VW'(i_src.source_node);
                                r_div_dvs <= radix_eff;
                                if (dims_eff == '0) begin
                                    // no coordinates: destination zero
                                    r_res_dst <= '0;
                                    r_res_err <= (i_src.source_node == '0);
                                end else begin
                                    r_div_start <= 1'b1;
                                    r_state     <= S_XDIV;
                                end
                            end
                            PAT_REVERSAL:   r_res_dst <= rev_dst;
                            PAT_SHUFFLE:    r_res_dst <= shuf_dst;
                            PAT_BUTTERFLY:  r_res_dst <= bfly_dst;
                            PAT_COMPLEMENT: r_res_dst <= s_low ^ mask;
                            PAT_TORNADO: begin
                                r_res_dst <= i_src.source_node;
                                r_div_dvd <= torn_num;
                                r_div_dvs <= r_node_count;
                                if (r_node_count != '0) begin
                                    r_div_start <= 1'b1;
                                    r_state     <= S_TDIV;
                                end
                            end
                            PAT_ALL_TO_ALL: begin
                                r_res_dst <= a2a_dst;
                                r_ptr     <= f_inc(a2a_dst, r_node_count);
                            end
                            default: r_res_dst <= '0;
                        endcase
                    end
                end
                S_TDIV: begin
                    if (div_done) begin
                        r_res_dst <= div_rem[NW-1:0];
                        r_state   <= S_OUT;
                    end
                end
                S_XDIV: begin
                    if (div_done) begin
                        // complement the coordinate modulo the radix
                        r_coord[r_dim_cnt[DIW-1:0]] <= radix_eff - CW'(1) - div_rem;
                        r_dim_cnt <= r_dim_cnt + DCW'(1);
                        if ((r_dim_cnt + DCW'(1)) == dims_eff) begin
                            r_asm_cnt <= '0;
                            r_acc     <= '0;
                            r_big     <= 1'b0;
                            r_state   <= S_ASM1;
                        end else begin
                            r_div_dvd   <= div_quo;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_ASM1: begin
                    r_acc     <= mac_low;
                    r_big     <= mac_big;
                    r_asm_cnt <= r_asm_cnt + DCW'(1);
                    if (asm_last) begin
                        if (mac_eq) begin
                            // still the source: retry in the original order
                            r_asm_cnt <= '0;
                            r_acc     <= '0;
                            r_big     <= 1'b0;
                            r_state   <= S_ASM2;
                        end else begin
                            r_res_dst <= mac_low;
                            r_state   <= S_OUT;
                        end
                    end
                end
                S_ASM2: begin
                    r_acc     <= mac_low;
                    r_big     <= mac_big;
                    r_asm_cnt <= r_asm_cnt + DCW'(1);
                    if (asm_last) begin
                        r_res_err <= mac_eq;
                        r_res_dst <= mac_eq ? r_src : mac_low;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_src.ready            = (r_state == S_IDLE);
    assign o_dst.valid            = r_out_valid;
    assign o_dst.destination_node = r_out_dst;
    assign o_dst.unchanged_error  = r_out_err;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic st_div;
    logic st_asm;
    logic res_flagged;
    logic a2a_acc;
    logic ptr_ok;

    assign st_div      = (r_state == S_TDIV) || (r_state == S_XDIV);
    assign st_asm      = (r_state == S_ASM1) || (r_state == S_ASM2);
    assign res_flagged = (r_state == S_OUT) && r_res_err;
    assign a2a_acc     = in_acc && (r_pattern == PAT_ALL_TO_ALL);
    assign ptr_ok      = (r_ptr == '0) || (CW'(r_ptr) < r_node_count);

    `NTD_ASSERT_NOW(a_div_done_waited, div_done, st_div, "divider done outside a divide state")
    `NTD_ASSERT_NOW(a_asm_idx_range, st_asm, r_asm_cnt < dims_eff, "assembly overran")
    `NTD_ASSERT_NOW(a_err_gives_src, res_flagged, r_res_dst == r_src, "flag without source")
    `NTD_ASSERT_NEXT(a_ptr_wrapped, a2a_acc, ptr_ok, "pointer not wrapped")
endmodule

// ===== tb/sv/ntd_destination_checker.sv =====
`timescale 1ns / 1ps

module ntd_destination_checker #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_DIMS  = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ntd_src_if                          i_src,
    ntd_dst_if                          i_dst,
    input  logic                        i_cfg_we,
    input  ntd_pkg::t_reg_index         i_cfg_index,
    input  logic [$clog2(MAX_NODES):0]  i_cfg_data,
    output int unsigned                 o_fail_count,
    output int unsigned                 o_pending,
    output int unsigned                 o_checked
);
    import ntd_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CFG_W  = NODE_W + 1;

    typedef struct packed {
        logic [NODE_W-1:0] destination_node;
        logic              unchanged_error;
    } t_route;

    // shadow copy of the unit's registers and all-to-all pointer
    t_pattern          pattern_q;
    logic [CFG_W-1:0]  node_count_q;
    logic [CFG_W-1:0]  radix_q;
    logic [DIM_W-1:0]  dims_q;
    logic [NODE_W-1:0] a2a_ptr;

    t_route      routes_in_flight[$];
    int unsigned fail_cnt    = 0;
    int unsigned checked_cnt = 0;

    // bit length of node_count-1 equals clog2(node_count) once the count exceeds two
    function automatic int unsigned pattern_bits();
        int unsigned b;
        if (node_count_q < 3) return 1;
        b = $clog2(node_count_q);
        return (b > NODE_W) ? NODE_W : b;
    endfunction

    function automatic logic [NODE_W-1:0] next_ptr(input logic [NODE_W-1:0] p);
        int unsigned q;
        q = p + 1;
        return (q >= node_count_q) ? '0 : q[NODE_W-1:0];
    endfunction

    function automatic t_route transpose_route(input logic [NODE_W-1:0] src);
        longint unsigned digit [1:MAX_DIMS];
        longint unsigned r, q, c, acc;
        int              d;
        t_route          res;
        r   = (radix_q < 2) ? 2 : radix_q;
        d   = (dims_q > MAX_DIMS) ? MAX_DIMS : dims_q;
        q   = src;
        acc = 0;
        for (int i = 1; i <= d; i++) begin
            // top coordinate keeps whatever is left of the quotient
            c        = (i != d) ? q % r : q;
            q        = q / r;
            digit[i] = (r - 1 + r - (c % r)) % r;
        end
        for (int i = 1; i <= d; i++) acc = acc * r + digit[i];
        if (acc == src) begin
            acc = 0;
            for (int i = d; i >= 1; i--) acc = acc * r + digit[i];
        end
        res.unchanged_error  = (acc == src);
        res.destination_node = res.unchanged_error ? src : acc[NODE_W-1:0];
        return res;
    endfunction

    function automatic t_route predict_route(input logic [NODE_W-1:0] src);
        int unsigned       b, m, s, dv, nc, src_v;
        logic [NODE_W-1:0] p;
        t_route            res;
        b     = pattern_bits();
        m     = (1 << b) - 1;
        src_v = src;
        s     = src_v & m;
        nc    = node_count_q;
        dv    = 0;
        case (pattern_q)
            PAT_REVERSAL: begin
                for (int i = 0; i < b; i++)
                    if ((s >> i) & 1) dv |= 1 << (b - 1 - i);
                if (dv == s) dv ^= m;
            end
            PAT_SHUFFLE: begin
                dv = ((s << 1) & m) | (s >> (b - 1));
                if (dv == s) dv ^= m;
            end
            PAT_BUTTERFLY: begin
                dv = s;
                if (((s >> (b - 1)) & 1) != (s & 1)) dv = s ^ ((1 << (b - 1)) | 1);
                if (dv == s) dv ^= m;
            end
            PAT_COMPLEMENT: dv = s ^ m;
            PAT_TORNADO: dv = (nc == 0) ? src_v : (src_v + nc / 2 + nc - 1) % nc;
            PAT_ALL_TO_ALL: begin
                p = a2a_ptr;
                if (p == src) p = next_ptr(p);
                dv      = p;
                a2a_ptr = next_ptr(p);
            end
            default: dv = 0;
        endcase
        if (pattern_q == PAT_TRANSPOSE) begin
            res = transpose_route(src);
        end else begin
            res.destination_node = dv[NODE_W-1:0];
            res.unchanged_error  = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_route seen;
        t_route want;
        if (!i_rst_n) begin
            pattern_q    = t_pattern'(RST_PATTERN);
            node_count_q = CFG_W'(RST_NODE_COUNT);
            radix_q      = CFG_W'(RST_RADIX);
            dims_q       = DIM_W'(RST_DIMENSIONS);
            a2a_ptr      = '0;
            routes_in_flight.delete();
        end else begin
            if (i_dst.valid && i_dst.ready) begin
                seen.destination_node = i_dst.destination_node;
                seen.unchanged_error  = i_dst.unchanged_error;
                if (routes_in_flight.size() == 0) begin
                    fail_cnt++;
                    $error("unexpected result: destination_node %0d, unchanged_error %0b",
                           seen.destination_node, seen.unchanged_error);
                end else begin
                    want = routes_in_flight.pop_front();
                    checked_cnt++;
                    if (seen.destination_node !== want.destination_node) begin
                        fail_cnt++;
                        $error("destination_node mismatch: expected %0d, actual %0d",
                               want.destination_node, seen.destination_node);
                    end
                    if (seen.unchanged_error !== want.unchanged_error) begin
                        fail_cnt++;
                        $error("unchanged_error mismatch: expected %0b, actual %0b",
                               want.unchanged_error, seen.unchanged_error);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_PATTERN:    pattern_q    = i_cfg_data[PAT_W-1:0];
                    REG_NODE_COUNT: node_count_q = i_cfg_data;
                    REG_RADIX:      radix_q      = i_cfg_data;
                    REG_DIMENSIONS: dims_q       = i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_src.valid && i_src.ready)
                routes_in_flight = {routes_in_flight, predict_route(i_src.source_node)};
        end
        o_fail_count <= fail_cnt;
        o_pending    <= routes_in_flight.size();
        o_checked    <= checked_cnt;
    end

endmodule

// ===== tb/sv/tb_noc_traffic_destination_unit.sv =====
`timescale 1ns / 1ps

module tb_noc_traffic_destination_unit;
    import ntd_pkg::*;

    localparam int MAX_NODES = 1024;
    localparam int MAX_DIMS  = 4;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CFG_W     = NODE_W + 1;

    // unused pattern code: the unit must answer with a zero destination
    localparam t_pattern PAT_UNUSED = 3'd7;

    localparam int TOTAL_ITEMS   = 2000;
    // receiver holds off once, after this many source items have been offered
    localparam int PRESSURE_AT   = 600;
    localparam int LONG_HOLD     = 300;
    // idle cycles after the last result before the registers are touched
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 150;
    // slowest legal run: all transposes with the longest gaps on both sides; the timeout
    // allows several times that, counted in ns at a 2 ns clock period
    localparam int TIMEOUT_NS    = 4_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    t_reg_index       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    ntd_src_if #(.NODE_W(NODE_W)) src_ch ();
    ntd_dst_if #(.NODE_W(NODE_W)) dst_ch ();

    int unsigned fail_count;
    int unsigned pending_routes;
    int unsigned checked_routes;

    // stimulus bookkeeping, written by the stimulus process only
    int unsigned items_sent  = 0;
    int unsigned config_sets = 0;
    int unsigned cur_nodes;
    t_pattern    cur_pattern;
    bit          idle_on;
    bit          hold_now    = 1'b0;
    int unsigned pattern_items [0:7] = '{default: 0};

    always #1 i_clk = ~i_clk;

    noc_traffic_destination_unit #(
        .MAX_NODES (MAX_NODES),
        .MAX_DIMS  (MAX_DIMS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_src       (src_ch),
        .o_dst       (dst_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ntd_destination_checker #(
        .MAX_NODES (MAX_NODES),
        .MAX_DIMS  (MAX_DIMS)
    ) route_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_src        (src_ch),
        .i_dst        (dst_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_routes),
        .o_checked    (checked_routes)
    );

    // Gap length for either side: mostly none or short, now and then long.
    // With idling switched off the channel runs flat out.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one source node and hold it until the transfer completes. Valid is
    // only dropped when a gap follows, so back-to-back items keep it high.
    task automatic send_node(input logic [NODE_W-1:0] node);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            src_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_ch.valid       <= 1'b1;
        src_ch.source_node <= node;
        pattern_items[cur_pattern]++;
        items_sent++;
        @(posedge i_clk);
        while (!src_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted route to come back, then let
    // the unit fall idle before anything else touches it.
    task automatic settle();
        src_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_routes != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; write enable stays high across them.
    task automatic set_config(input t_pattern pat, input int unsigned nodes,
                              input int unsigned rdx, input int unsigned dims);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PATTERN;
        cfg_data  <= CFG_W'(pat);
        @(posedge i_clk);
        cfg_index <= REG_NODE_COUNT;
        cfg_data  <= CFG_W'(nodes);
        @(posedge i_clk);
        cfg_index <= REG_RADIX;
        cfg_data  <= CFG_W'(rdx);
        @(posedge i_clk);
        cfg_index <= REG_DIMENSIONS;
        cfg_data  <= CFG_W'(dims);
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        cur_pattern = pat;
        cur_nodes   = nodes;
        config_sets++;
    endtask

    initial begin : stimulus
        int unsigned       roll, nodes, rdx, dims, span, chunk;
        t_pattern          pat;
        logic [NODE_W-1:0] node;

        i_rst_n            <= 1'b0;
        src_ch.valid       <= 1'b0;
        src_ch.source_node <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_PATTERN;
        cfg_data           <= '0;
        cur_pattern = t_pattern'(RST_PATTERN);
        cur_nodes   = RST_NODE_COUNT;
        idle_on     = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset defaults first: transpose, 16 nodes, radix 4, 2 dims.
        send_node(0);       // every coordinate complemented
        send_node(9);       // reversed order lands on the source: fall back to plain order
        send_node(1023);    // far beyond the node count; the top coordinate is still taken modulo the radix

        // both orders land on the source: flag the error and echo the source
        set_config(PAT_TRANSPOSE, 9, 3, 2);
        send_node(4);
        set_config(PAT_TRANSPOSE, 3, 3, 1);
        send_node(1);
        // no dimensions at all: destination 0, so source 0 raises the flag
        set_config(PAT_TRANSPOSE, MAX_NODES, MAX_NODES, 0);
        send_node(0);
        // radix of one counts as two; dimensions above the maximum are clamped
        set_config(PAT_TRANSPOSE, MAX_NODES, 1, 7);
        send_node(1023);

        // bit patterns over the full ten-bit space, including a self-mapped node
        for (int p = PAT_REVERSAL; p <= PAT_COMPLEMENT; p++) begin
            set_config(t_pattern'(p), MAX_NODES, 4, 2);
            send_node(0);
            send_node(10'h155);
        end
        // one-bit space: shuffle maps every node onto itself
        set_config(PAT_SHUFFLE, 2, 4, 2);
        send_node(1);

        // tornado with zero and one nodes, then the widest count
        set_config(PAT_TORNADO, 0, 4, 2);
        send_node(7);
        set_config(PAT_TORNADO, 1, 4, 2);
        send_node(5);
        set_config(PAT_TORNADO, MAX_NODES, 4, 2);
        send_node(1023);

        // all-to-all: skip the source, wrap at the count, then shrink the count
        // below the pointer so the stale pointer is emitted as it stands
        set_config(PAT_ALL_TO_ALL, 4, 4, 2);
        send_node(0);
        send_node(1);
        send_node(3);
        send_node(3);
        set_config(PAT_ALL_TO_ALL, 2, 4, 2);
        send_node(0);

        set_config(PAT_UNUSED, 16, 4, 2);
        send_node(5);

        // Random part: phases of one register setting each, with random traffic.
        while (items_sent < TOTAL_ITEMS) begin
            pat = ($urandom_range(0, 19) == 0) ? PAT_UNUSED
                : t_pattern'($urandom_range(PAT_TRANSPOSE, PAT_ALL_TO_ALL));
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                // well-formed array: node count is radix to the power of dimensions
                dims = $urandom_range(1, MAX_DIMS);
                span = 2;
                while ((span + 1) ** dims <= MAX_NODES) span++;
                rdx   = $urandom_range(2, span);
                nodes = rdx ** dims;
            end else if (roll < 8) begin
                nodes = $urandom_range(2, MAX_NODES);
                rdx   = $urandom_range(2, MAX_NODES);
                dims  = $urandom_range(1, MAX_DIMS);
            end else if (roll < 9) begin
                // anything the register fields hold, degenerate values included
                nodes = $urandom_range(0, 2 ** CFG_W - 1);
                rdx   = $urandom_range(0, 2 ** CFG_W - 1);
                dims  = $urandom_range(0, 2 ** DIM_W - 1);
            end else begin
                nodes = 1 << $urandom_range(1, NODE_W);
                rdx   = nodes;
                dims  = 1;
            end
            set_config(pat, nodes, rdx, dims);
            idle_on = ($urandom_range(0, 3) != 0);
            chunk   = $urandom_range(15, 60);
            if (!hold_now && items_sent >= PRESSURE_AT) begin
                // long flat-out burst while the receiver holds off
                hold_now = 1'b1;
                idle_on  = 1'b0;
                chunk    = 64;
            end
            span    = (cur_nodes == 0 || cur_nodes > MAX_NODES) ? MAX_NODES : cur_nodes;
            repeat (chunk) begin
                // mostly legal sources, some from the whole field
                if ($urandom_range(0, 4) == 0) node = $urandom_range(0, MAX_NODES - 1);
                else                           node = $urandom_range(0, span - 1);
                send_node(node);
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Covered %0d checked transfers across %0d register settings.",
                 checked_routes, config_sets);
        $display("Items per pattern: transpose %0d, reversal %0d, shuffle %0d, %s %0d, %s %0d, %s",
                 pattern_items[PAT_TRANSPOSE], pattern_items[PAT_REVERSAL],
                 pattern_items[PAT_SHUFFLE], "butterfly", pattern_items[PAT_BUTTERFLY],
                 "complement", pattern_items[PAT_COMPLEMENT],
                 $sformatf("tornado %0d, all-to-all %0d, unused code %0d",
                           pattern_items[PAT_TORNADO], pattern_items[PAT_ALL_TO_ALL],
                           pattern_items[PAT_UNUSED]));
        if (fail_count == 0) begin
            $display("noc_traffic_destination_unit regression: pass");
        end else begin
            $display("noc_traffic_destination_unit regression: fail");
        end
        $finish;
    end

    // Result side: short ready bursts broken by stalls of random length, plus a
    // single long hold-off so the unit fills up and back-pressures the source.
    initial begin : result_sink
        int unsigned stall;
        bit          pressure_done;
        pressure_done = 1'b0;
        dst_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!pressure_done && hold_now) begin
                pressure_done = 1'b1;
                dst_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall != 0) begin
                    dst_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            dst_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Hard stop should the unit hang.
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("noc_traffic_destination_unit regression: fail");
        $finish;
    end

endmodule
